### rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared definitions for the coordinate hash set
// Default sizes, field widths and the command codes of the request channel.
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int BUCKETS_DEF    = 64;
	localparam int SLOTS_DEF      = 8;
	localparam int COORD_BITS_DEF = 16;

	localparam int POS_W   = 16;
	localparam int TOTAL_W = 10;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

endpackage

### rtl/chs_req_if.sv
// ----------------------------------------------------------------------------
// chs_req_if: request channel of the coordinate hash set
// Valid/ready channel that carries one command and one coordinate pair per beat.
// ----------------------------------------------------------------------------
interface chs_req_if;

	logic                        valid;
	logic                        ready;
	chs_pkg::cmd_t               cmd;
	logic [chs_pkg::POS_W-1:0]   pos_x;
	logic [chs_pkg::POS_W-1:0]   pos_y;

	modport source (output valid, output cmd, output pos_x, output pos_y, input ready);
	modport sink   (input valid, input cmd, input pos_x, input pos_y, output ready);

endinterface

### rtl/chs_rsp_if.sv
// ----------------------------------------------------------------------------
// chs_rsp_if: response channel of the coordinate hash set
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface chs_rsp_if;

	logic                          valid;
	logic                          ready;
	logic                          found;
	logic                          stored;
	logic                          bucket_full;
	logic [chs_pkg::TOTAL_W-1:0]   total_entries;

	modport source (output valid, output found, output stored, output bucket_full,
		output total_entries, input ready);
	modport sink   (input valid, input found, input stored, input bucket_full,
		input total_entries, output ready);

endinterface

### rtl/chs_ram.sv
// ----------------------------------------------------------------------------
// chs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/coordinate_hash_set_unit.sv
// ----------------------------------------------------------------------------
// coordinate_hash_set_unit: set of (x, y) pairs with fixed-slot buckets
// Insert-if-absent and lookup of coordinate pairs, hashed by (x*y) mod BUCKETS.
// ----------------------------------------------------------------------------
// After reset the unit clears the fill count of every bucket and takes no
// request meanwhile. Each request is then worked on alone, in these steps:
// register it, multiply, reduce the product to a bucket (a bit slice when
// BUCKETS is a power of two, else a remainder taken four product bits at a
// time), read the bucket fill count, walk the filled slots of the bucket
// (skipped for an empty bucket) through the single read port of the slot RAM
// and one comparator, update, and hand the result to the output register;
// this last step waits until that register is free. A finished result waits
// in the output register while the next request is taken.
module coordinate_hash_set_unit #(
	parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
	parameter int SLOTS      = chs_pkg::SLOTS_DEF,
	parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	chs_req_if.sink     req,
	chs_rsp_if.source   rsp
);

	localparam int KEEP_BITS = (COORD_BITS < chs_pkg::POS_W) ? COORD_BITS : chs_pkg::POS_W;
	localparam int KEY_W     = 2 * KEEP_BITS;
	localparam int PROD_W    = 2 * KEEP_BITS;
	localparam int BUCKET_AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SLOT_AW   = (BUCKETS * SLOTS > 1) ? $clog2(BUCKETS * SLOTS) : 1;
	localparam int FILL_W    = $clog2(SLOTS + 1);
	localparam int WIDE_W    = (PROD_W > BUCKET_AW) ? PROD_W : BUCKET_AW;
	localparam int DIGITS    = (WIDE_W + 3) / 4;
	localparam int PAD_W     = DIGITS * 4;
	localparam int DIG_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int REM_W     = ($clog2(BUCKETS) + 1 > 2) ? $clog2(BUCKETS) + 1 : 2;
	localparam bit POW2      = (BUCKETS & (BUCKETS - 1)) == 0;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_MOD,
		ST_FILL_RD,
		ST_FILL_CAP,
		ST_SCAN,
		ST_DECIDE,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [BUCKET_AW-1:0]        clr_q;
	chs_pkg::cmd_t               cmd_q;
	logic [KEEP_BITS-1:0]        x_q;
	logic [KEEP_BITS-1:0]        y_q;
	logic [PAD_W-1:0]            prod_q;
	logic [REM_W-1:0]            rem_q;
	logic [DIG_W-1:0]            dig_q;
	logic [BUCKET_AW-1:0]        bucket_q;
	logic [FILL_W-1:0]           fill_q;
	logic [FILL_W-1:0]           idx_q;
	logic                        pend_q;
	logic                        found_q;
	logic [chs_pkg::TOTAL_W-1:0] total_q;

	logic                        out_valid_q;
	logic                        out_found_q;
	logic                        out_stored_q;
	logic                        out_full_q;
	logic [chs_pkg::TOTAL_W-1:0] out_total_q;

	logic [REM_W-1:0]            rem_next;
	logic [BUCKET_AW-1:0]        bucket_next;
	logic [SLOT_AW-1:0]          base;
	logic [KEY_W-1:0]            key;
	logic                        match;
	logic                        out_free;
	logic                        do_insert;

	logic                        fill_we;
	logic [BUCKET_AW-1:0]        fill_waddr;
	logic [FILL_W-1:0]           fill_wdata;
	logic [FILL_W-1:0]           fill_rdata;
	logic                        slot_we;
	logic [SLOT_AW-1:0]          slot_addr_w;
	logic [SLOT_AW-1:0]          slot_addr_r;
	logic [KEY_W-1:0]            slot_rdata;

	// four restoring remainder steps per cycle, product taken msb first
	always_comb begin
		logic [REM_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < 4; i++) begin
			r = {r[REM_W-2:0], prod_q[PAD_W-1-i]};
			if (r >= REM_W'(BUCKETS)) begin
				r = r - REM_W'(BUCKETS);
			end
		end
		rem_next = r;
	end

	always_comb begin
		if (BUCKETS == 1) begin
			bucket_next = '0;
		end else if (POW2) begin
			bucket_next = prod_q[BUCKET_AW-1:0];
		end else begin
			bucket_next = rem_next[BUCKET_AW-1:0];
		end
	end

	assign base      = SLOT_AW'(bucket_q) * SLOT_AW'(SLOTS);
	assign key       = {x_q, y_q};
	assign match     = pend_q && (slot_rdata == key);
	assign out_free  = !out_valid_q || rsp.ready;
	assign do_insert = (cmd_q == chs_pkg::CMD_INSERT) && !found_q && (fill_q < FILL_W'(SLOTS));

	always_comb begin
		fill_we     = 1'b0;
		fill_waddr  = bucket_q;
		fill_wdata  = fill_q + FILL_W'(1);
		slot_we     = 1'b0;
		slot_addr_w = base + SLOT_AW'(fill_q);
		slot_addr_r = base + SLOT_AW'(idx_q);
		unique case (state_q)
			ST_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
			end
			ST_DECIDE: begin
				fill_we = do_insert;
				slot_we = do_insert;
			end
			default: begin
			end
		endcase
	end

	chs_ram #(
		.WIDTH (FILL_W),
		.DEPTH (BUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (bucket_q),
		.rdata (fill_rdata)
	);

	chs_ram #(
		.WIDTH (KEY_W),
		.DEPTH (BUCKETS * SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_addr_w),
		.wdata (key),
		.raddr (slot_addr_r),
		.rdata (slot_rdata)
	);

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.found         = out_found_q;
	assign rsp.stored        = out_stored_q;
	assign rsp.bucket_full   = out_full_q;
	assign rsp.total_entries = out_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
			cmd_q        <= chs_pkg::CMD_LOOKUP;
			x_q          <= '0;
			y_q          <= '0;
			prod_q       <= '0;
			rem_q        <= '0;
			dig_q        <= '0;
			bucket_q     <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			found_q      <= 1'b0;
			out_found_q  <= 1'b0;
			out_stored_q <= 1'b0;
			out_full_q   <= 1'b0;
			out_total_q  <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BUCKET_AW'(1);
					if (clr_q == BUCKET_AW'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						x_q     <= req.pos_x[KEEP_BITS-1:0];
						y_q     <= req.pos_y[KEEP_BITS-1:0];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PAD_W'(x_q) * PAD_W'(y_q);
					rem_q   <= '0;
					dig_q   <= '0;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (POW2 || dig_q == DIG_W'(DIGITS - 1)) begin
						bucket_q <= bucket_next;
						state_q  <= ST_FILL_RD;
					end else begin
						rem_q  <= rem_next;
						prod_q <= prod_q << 4;
						dig_q  <= dig_q + DIG_W'(1);
					end
				end
				ST_FILL_RD: begin
					state_q <= ST_FILL_CAP;
				end
				ST_FILL_CAP: begin
					fill_q  <= fill_rdata;
					idx_q   <= '0;
					pend_q  <= 1'b0;
					found_q <= 1'b0;
					state_q <= (fill_rdata == '0) ? ST_DECIDE : ST_SCAN;
				end
				ST_SCAN: begin
					// read of slot idx_q issued now, compare of the previous slot
					pend_q <= (idx_q < fill_q);
					idx_q  <= idx_q + FILL_W'(1);
					if (match) begin
						found_q <= 1'b1;
						state_q <= ST_DECIDE;
					end else if (idx_q >= fill_q) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (do_insert && total_q != chs_pkg::TOTAL_MAX) begin
						total_q <= total_q + chs_pkg::TOTAL_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_found_q  <= found_q;
						out_stored_q <= do_insert;
						out_full_q   <= (cmd_q == chs_pkg::CMD_INSERT) && !found_q && !do_insert;
						out_total_q  <= total_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the coordinate hash set unit
// Drives insert and lookup beats through the request channel, predicts each
// result with a behavioral copy of the bucketed set and checks every response.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int N_BUCKETS  = chs_pkg::BUCKETS_DEF;
	localparam int N_SLOTS    = chs_pkg::SLOTS_DEF;
	localparam int N_DIRECTED = 22;
	localparam int N_RANDOM   = 1630;
	localparam int IDLE_PCT   = 16;
	localparam int STALL_MAX  = 2000;
	localparam int DRAIN_CYC  = 30;

	typedef struct packed {
		logic                        found;
		logic                        stored;
		logic                        bucket_full;
		logic [chs_pkg::TOTAL_W-1:0] total;
	} set_result_t;

	typedef struct packed {
		chs_pkg::cmd_t             cmd;
		logic [chs_pkg::POS_W-1:0] x;
		logic [chs_pkg::POS_W-1:0] y;
		logic                      typed;
		set_result_t               res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic quiet;

	chs_req_if req_bus ();
	chs_rsp_if rsp_bus ();

	coordinate_hash_set_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// shadow copy of the set
	logic [2*chs_pkg::POS_W-1:0] slot_key     [N_BUCKETS][N_SLOTS];
	int                          bucket_count [N_BUCKETS];
	int                          pair_total;

	set_result_t                 pending_results [$];
	logic [2*chs_pkg::POS_W-1:0] stored_keys [$];
	dir_row_t                    dir_rows [N_DIRECTED];
	int                          errors;
	int                          idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic set_result_t apply_to_set(chs_pkg::cmd_t cmd,
		logic [chs_pkg::POS_W-1:0] x, logic [chs_pkg::POS_W-1:0] y);
		logic [2*chs_pkg::POS_W-1:0] key;
		logic [2*chs_pkg::POS_W-1:0] prod;
		int                          b;
		int                          fill;
		set_result_t                 r;
		key  = {x, y};
		prod = x * y;
		b    = int'(prod % N_BUCKETS);
		fill = bucket_count[b];
		r    = '0;
		for (int i = 0; i < fill; i++) begin
			if (slot_key[b][i] == key)
				r.found = 1'b1;
		end
		if (cmd == chs_pkg::CMD_INSERT && !r.found) begin
			if (fill < N_SLOTS) begin
				slot_key[b][fill] = key;
				bucket_count[b]   = fill + 1;
				pair_total++;
				r.stored = 1'b1;
			end else begin
				r.bucket_full = 1'b1;
			end
		end
		r.total = (pair_total > int'(chs_pkg::TOTAL_MAX)) ? chs_pkg::TOTAL_MAX :
			chs_pkg::TOTAL_W'(pair_total);
		return r;
	endfunction

	function automatic void check_field(string name, int expv, int actv);
		if (expv != actv) begin
			$error("%s mismatch: expected %0d, got %0d", name, expv, actv);
			errors++;
		end
	endfunction

	// one request beat; the expectation is queued once the beat is taken
	task automatic drive_item(chs_pkg::cmd_t cmd, logic [chs_pkg::POS_W-1:0] x,
		logic [chs_pkg::POS_W-1:0] y, logic typed, set_result_t typed_res);
		set_result_t r;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.cmd   <= cmd;
		req_bus.pos_x <= x;
		req_bus.pos_y <= y;
		do
			@(posedge clk);
		while (!req_bus.ready);
		r = apply_to_set(cmd, x, y);
		if (r.stored)
			stored_keys.push_back({x, y});
		pending_results.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	// response side stalls
	always @(negedge clk)
		rsp_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		set_result_t e;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				$error("response beat with no request outstanding");
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("found", e.found, rsp_bus.found);
				check_field("stored", e.stored, rsp_bus.stored);
				check_field("bucket_full", e.bucket_full, rsp_bus.bucket_full);
				check_field("total_entries", e.total, rsp_bus.total_entries);
			end
		end
	end

	// watchdog: cycles without any beat on either channel
	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_MAX) begin
			$display("[coordinate_hash_set_unit] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		chs_pkg::cmd_t               cmd;
		logic [chs_pkg::POS_W-1:0]   x;
		logic [chs_pkg::POS_W-1:0]   y;
		logic [2*chs_pkg::POS_W-1:0] pick;
		int                          kind;
		arst_n        = 1'b0;
		quiet         = 1'b0;
		pair_total    = 0;
		req_bus.valid = 1'b0;
		req_bus.cmd   = chs_pkg::CMD_INSERT;
		req_bus.pos_x = '0;
		req_bus.pos_y = '0;
		foreach (bucket_count[i])
			bucket_count[i] = 0;

		// bucket 0 gets filled, then overflowed and probed
		dir_rows = '{
			'{chs_pkg::CMD_LOOKUP, 16'd0,    16'd0,    1'b1, '{1'b0, 1'b0, 1'b0, 10'd0}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd0,    1'b1, '{1'b0, 1'b1, 1'b0, 10'd1}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd0,    1'b1, '{1'b1, 1'b0, 1'b0, 10'd1}},
			'{chs_pkg::CMD_LOOKUP, 16'd0,    16'd0,    1'b1, '{1'b1, 1'b0, 1'b0, 10'd1}},
			'{chs_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 1'b1, 1'b0, 10'd2}},
			'{chs_pkg::CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 1'b0, 10'd2}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd1,    1'b1, '{1'b0, 1'b1, 1'b0, 10'd3}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd2,    1'b1, '{1'b0, 1'b1, 1'b0, 10'd4}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd3,    1'b1, '{1'b0, 1'b1, 1'b0, 10'd5}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd4,    1'b1, '{1'b0, 1'b1, 1'b0, 10'd6}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd5,    1'b1, '{1'b0, 1'b1, 1'b0, 10'd7}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd6,    1'b1, '{1'b0, 1'b1, 1'b0, 10'd8}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd7,    1'b1, '{1'b0, 1'b1, 1'b0, 10'd9}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd8,    1'b1, '{1'b0, 1'b0, 1'b1, 10'd9}},
			'{chs_pkg::CMD_LOOKUP, 16'd0,    16'd8,    1'b1, '{1'b0, 1'b0, 1'b0, 10'd9}},
			'{chs_pkg::CMD_INSERT, 16'd1,    16'd64,   1'b1, '{1'b0, 1'b0, 1'b1, 10'd9}},
			'{chs_pkg::CMD_INSERT, 16'h8000, 16'd1,    1'b1, '{1'b0, 1'b0, 1'b1, 10'd9}},
			'{chs_pkg::CMD_INSERT, 16'd0,    16'd7,    1'b1, '{1'b1, 1'b0, 1'b0, 10'd9}},
			'{chs_pkg::CMD_INSERT, 16'd1234, 16'd4321, 1'b0, '0},
			'{chs_pkg::CMD_LOOKUP, 16'd4321, 16'd1234, 1'b0, '0},
			'{chs_pkg::CMD_INSERT, 16'd4321, 16'd1234, 1'b0, '0},
			'{chs_pkg::CMD_LOOKUP, 16'd1234, 16'd4321, 1'b0, '0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			drive_item(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed,
				dir_rows[i].res);

		for (int n = 0; n < N_RANDOM; n++) begin
			quiet = (n >= 500 && n < 800);
			kind  = int'($urandom_range(99));
			if (kind < 45 || stored_keys.size() == 0) begin
				// new pairs, mostly small so that buckets crowd and overflow
				cmd = chs_pkg::CMD_INSERT;
				if ($urandom_range(99) < 30) begin
					x = chs_pkg::POS_W'($urandom);
					y = chs_pkg::POS_W'($urandom);
				end else begin
					x = chs_pkg::POS_W'($urandom_range(0, 255));
					y = chs_pkg::POS_W'($urandom_range(0, 255));
				end
				if (kind >= 90)
					cmd = chs_pkg::CMD_LOOKUP;
			end else begin
				pick = stored_keys[$urandom_range(stored_keys.size() - 1)];
				cmd  = (kind < 70) ? chs_pkg::CMD_INSERT : chs_pkg::CMD_LOOKUP;
				// swapped pair hashes to the same bucket but is another key
				if (kind >= 90) begin
					x = pick[chs_pkg::POS_W-1:0];
					y = pick[2*chs_pkg::POS_W-1:chs_pkg::POS_W];
				end else begin
					x = pick[2*chs_pkg::POS_W-1:chs_pkg::POS_W];
					y = pick[chs_pkg::POS_W-1:0];
				end
			end
			drive_item(cmd, x, y, 1'b0, '0);
		end
		quiet         = 1'b0;
		req_bus.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (errors == 0) begin
			$display("[coordinate_hash_set_unit] OK");
		end else begin
			$display("[coordinate_hash_set_unit] ERROR");
		end
		$finish;
	end

endmodule

### sim.f
rtl/chs_pkg.sv
rtl/chs_req_if.sv
rtl/chs_rsp_if.sv
rtl/chs_ram.sv
rtl/coordinate_hash_set_unit.sv
bench/tb_top.sv
